/* rtl/eaxa_pkg.sv */
package eaxa_pkg;

    localparam int BYTES_PER_CHANNEL_BLOCK_DEF = 15;
    localparam int COEF_W = 10;
    localparam int HIST_W = 32;
    localparam int SHIFT_W = 5;
    localparam int SEL_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 1'd1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd8;
    localparam logic signed [HIST_W-1:0] ROUND_BIAS = 32'sh0000_0080;
    localparam logic signed [HIST_W-1:0] CLIP_MAX = 32'sd32767;
    localparam logic signed [HIST_W-1:0] CLIP_MIN = -32'sd32768;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       new_stream;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] first_sample;
        logic signed [15:0] second_sample;
        logic               right_channel;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic clear_hist;
        logic hdr_we;
        logic ch;
        logic mul;
        logic acc;
        logic lo;
        logic out_load;
    } t_dp_cmd;

    function automatic logic signed [COEF_W-1:0] coef_rom(input logic [4:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            5'd1:    c = 10'sd240;
            5'd2:    c = 10'sd460;
            5'd3:    c = 10'sd392;
            5'd6:    c = -10'sd208;
            5'd7:    c = -10'sd220;
            5'd9:    c = 10'sd1;
            5'd10:   c = 10'sd3;
            5'd11:   c = 10'sd4;
            5'd12:   c = 10'sd7;
            5'd13:   c = 10'sd8;
            5'd14:   c = 10'sd10;
            5'd15:   c = 10'sd11;
            5'd17:   c = -10'sd1;
            5'd18:   c = -10'sd3;
            5'd19:   c = -10'sd4;
            default: c = 10'sd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/eaxa_ctrl.sv */
module eaxa_ctrl import eaxa_pkg::*; #(
    parameter int BYTES_PER_CHANNEL_BLOCK = BYTES_PER_CHANNEL_BLOCK_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_new_stream,
    input  logic    i_stereo,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam int POS_W = $clog2(2 * BYTES_PER_CHANNEL_BLOCK + 1);
    localparam logic [POS_W-1:0] LEN_MONO = POS_W'(BYTES_PER_CHANNEL_BLOCK);
    localparam logic [POS_W-1:0] LEN_STEREO = POS_W'(2 * BYTES_PER_CHANNEL_BLOCK);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_HI,
        S_ACC_HI,
        S_MUL_LO,
        S_ACC_LO,
        S_OUT
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    logic [POS_W-1:0] r_pos;

    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] n_pos;
    logic             is_hdr;
    logic             in_acc;
    logic             out_load;

    assign len      = i_stereo ? LEN_STEREO : LEN_MONO;
    assign pos_base = i_new_stream ? '0 : r_pos;
    assign pos_eff  = (pos_base >= len) ? '0 : pos_base;
    assign pos_inc  = pos_eff + POS_W'(1);
    assign n_pos    = (pos_inc >= len) ? '0 : pos_inc;
    assign is_hdr   = i_stereo ? (pos_eff < POS_W'(2)) : (pos_eff == '0);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = in_acc;
        o_cmd.clear_hist = in_acc && i_new_stream;
        o_cmd.hdr_we     = in_acc && is_hdr;
        o_cmd.ch         = i_stereo & pos_eff[0];
        o_cmd.mul        = (r_state == S_MUL_HI) || (r_state == S_MUL_LO);
        o_cmd.acc        = (r_state == S_ACC_HI) || (r_state == S_ACC_LO);
        o_cmd.lo         = (r_state == S_MUL_LO) || (r_state == S_ACC_LO);
        o_cmd.out_load   = out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos <= n_pos;
                        if (!is_hdr) begin
                            r_state <= S_MUL_HI;
                        end
                    end
                end
                S_MUL_HI: r_state <= S_ACC_HI;
                S_ACC_HI: r_state <= S_MUL_LO;
                S_MUL_LO: r_state <= S_ACC_LO;
                S_ACC_LO: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/eaxa_dp.sv */
module eaxa_dp import eaxa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  logic      i_clip,
    input  t_dp_cmd   i_cmd,
    output t_out_item o_out
);

    localparam int PROD_W = HIST_W + COEF_W;

    logic signed [HIST_W-1:0]  r_cur [2];
    logic signed [HIST_W-1:0]  r_prev [2];
    logic [SEL_W-1:0]          r_sel [2];
    logic [SHIFT_W-1:0]        r_shift [2];
    logic [7:0]                r_byte;
    logic                      r_ch;
    logic signed [HIST_W-1:0]  r_pc;
    logic signed [HIST_W-1:0]  r_pp;
    logic signed [HIST_W-1:0]  r_term;
    logic signed [15:0]        r_first;
    t_out_item                 r_out;

    logic [3:0]                nib;
    logic [4:0]                idx_cur;
    logic [4:0]                idx_prev;
    logic signed [PROD_W-1:0]  prod_cur;
    logic signed [PROD_W-1:0]  prod_prev;
    logic signed [HIST_W-1:0]  sum;
    logic signed [HIST_W-1:0]  shifted;
    logic signed [HIST_W-1:0]  n_cur;

    assign nib      = i_cmd.lo ? r_byte[3:0] : r_byte[7:4];
    assign idx_cur  = {1'b0, r_sel[r_ch]};
    assign idx_prev = idx_cur + 5'd4;
    assign prod_cur  = PROD_W'(r_cur[r_ch]) * PROD_W'(coef_rom(idx_cur));
    assign prod_prev = PROD_W'(r_prev[r_ch]) * PROD_W'(coef_rom(idx_prev));
    assign sum      = r_term + r_pc + r_pp + ROUND_BIAS;
    assign shifted  = sum >>> 8;

    always_comb begin
        n_cur = shifted;
        if (i_clip) begin
            priority if (shifted > CLIP_MAX) begin
                n_cur = CLIP_MAX;
            end else if (shifted < CLIP_MIN) begin
                n_cur = CLIP_MIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_cur[i]   <= '0;
                r_prev[i]  <= '0;
                r_sel[i]   <= '0;
                r_shift[i] <= SHIFT_RESET;
            end
        end else begin
            if (i_cmd.clear_hist) begin
                for (int i = 0; i < 2; i++) begin
                    r_cur[i]  <= '0;
                    r_prev[i] <= '0;
                end
            end
            if (i_cmd.hdr_we) begin
                r_sel[i_cmd.ch]   <= i_in.stream_byte[7:4];
                r_shift[i_cmd.ch] <= {1'b0, i_in.stream_byte[3:0]} + SHIFT_RESET;
            end
            if (i_cmd.acc) begin
                r_prev[r_ch] <= r_cur[r_ch];
                r_cur[r_ch]  <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in.stream_byte;
            r_ch   <= i_cmd.ch;
        end
        if (i_cmd.mul) begin
            r_pc   <= prod_cur[HIST_W-1:0];
            r_pp   <= prod_prev[HIST_W-1:0];
            r_term <= $signed({nib, 28'd0}) >>> r_shift[r_ch];
        end
        if (i_cmd.acc && !i_cmd.lo) begin
            r_first <= n_cur[15:0];
        end
        if (i_cmd.out_load) begin
            r_out.first_sample  <= r_first;
            r_out.second_sample <= r_cur[r_ch][15:0];
            r_out.right_channel <= r_ch;
        end
    end

    assign o_out = r_out;

endmodule

/* rtl/ea_xa_adpcm_decoder.sv */
// Decoder for EA XA ADPCM: one compressed byte per item. Header bytes load the
// predictor coefficients and shift of their channel and give no result; a data
// byte gives one result holding two 16-bit samples. A header byte leaves the
// decoder idle and ready for the next byte. A data byte holds off new input
// until its result is loaded: the two samples depend on each other, and each
// goes through a multiply step (both predictor products registered) and an
// accumulate step that updates the channel history, followed by the load of
// the output register. A finished result waits there while the next item is
// taken; a data byte that ends before that result is taken holds until it is.
module ea_xa_adpcm_decoder import eaxa_pkg::*; #(
    parameter int BYTES_PER_CHANNEL_BLOCK = BYTES_PER_CHANNEL_BLOCK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_stereo;
    logic    r_clip;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo <= 1'b0;
            r_clip   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEREO_MODE: r_stereo <= i_cfg_data[0];
                CFG_CLIP_ENABLE: r_clip   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    eaxa_ctrl #(
        .BYTES_PER_CHANNEL_BLOCK(BYTES_PER_CHANNEL_BLOCK)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_new_stream (i_in.new_stream),
        .i_stereo     (r_stereo),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (cmd)
    );

    eaxa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_clip  (r_clip),
        .i_cmd   (cmd),
        .o_out   (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("pending result overwritten");

    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && !cmd.hdr_we) |=> o_in_stall)
        else $error("data item did not hold off input");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.acc |-> $past(cmd.mul))
        else $error("accumulate without products");

    a_header_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.hdr_we |=> !cmd.out_load)
        else $error("header item produced a result");

endmodule
